>>> rtl/core/rilbp_pkg.sv
// ----------------------------------------------------------------------------
// rilbp_pkg
// Shared constants, types and function of the rotation invariant 3x3 LBP block.
// ----------------------------------------------------------------------------
package rilbp_pkg;

   // image geometry
   localparam int MAX_WIDTH       = 1024;
   localparam int PIXEL_BITS      = 8;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int ROW_BITS        = 16;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int NEIGHBOURS      = 8;
   localparam int CODE_BITS       = NEIGHBOURS;
   localparam int WINDOW_SIZE     = 9;

   // register reset values
   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(640);
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(480);

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = QUEUE_PTR_BITS + 1;

   // line buffer memory: upper row in the high half, middle row in the low half
   localparam int LINE_RAM_WIDTH = 2 * PIXEL_BITS;

   // one classified window waiting for the back end
   typedef struct packed {
      logic [NEIGHBOURS-1:0] bits;
      logic                  row_last;
      logic                  frame_last;
   } rilbp_entry_type;

   // front to queue
   typedef struct packed {
      logic            valid;
      rilbp_entry_type entry;
   } rilbp_push_type;

   // queue to back
   typedef struct packed {
      logic            not_empty;
      rilbp_entry_type entry;
   } rilbp_head_type;

   // smallest of the eight circular left rotations
   function automatic logic [CODE_BITS-1:0] min_rotation(input logic [NEIGHBOURS-1:0] b);
      logic [2*NEIGHBOURS-1:0] dbl;
      logic [CODE_BITS-1:0]    best;
      logic [CODE_BITS-1:0]    rot;
      dbl  = {b, b};
      best = b;
      for (int k = 1; k < NEIGHBOURS; k++) begin
         rot = dbl[2*NEIGHBOURS-1-k -: NEIGHBOURS];
         if (rot < best) begin
            best = rot;
         end
      end
      return best;
   endfunction

endpackage

>>> rtl/core/rilbp_if.sv
// ----------------------------------------------------------------------------
// rilbp channel interfaces
// Valid/ready channels for pixels, pattern results and register writes.
// ----------------------------------------------------------------------------

// pixel input channel
interface rilbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [rilbp_pkg::PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// pattern result channel
interface rilbp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rilbp_pkg::CODE_BITS-1:0] pattern_code;
   logic                            row_last;
   logic                            frame_last;

   modport source (output valid, output pattern_code, output row_last, output frame_last,
                   input ready);
   modport sink   (input valid, input pattern_code, input row_last, input frame_last,
                   output ready);
endinterface

// register write channel
interface rilbp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rilbp_pkg::CSR_INDEX_BITS-1:0] index;
   logic [rilbp_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rotation_invariant_lbp_3x3_top.sv
// ----------------------------------------------------------------------------
// rotation_invariant_lbp_3x3_top
// Rotation invariant local binary pattern over a 3x3 window, raster pixel in.
// ----------------------------------------------------------------------------
// usage
//   req_ch  : grayscale pixels in raster order, top-left first, one per
//             transaction. every pixel is consumed; border centres give nothing.
//   rsp_ch  : one transaction per interior centre: pattern_code is the smallest
//             of the eight rotations of the neighbour compare byte, row_last and
//             frame_last mark the last interior result of a row and a frame.
//   csr_ch  : index 0 image_width, index 1 image_height; always ready, write
//             only between frames or while the block holds no pending work.
// timing
//   a centre's result goes from the pixel that completes its window through
//   stage one, the queue and the output register. one pixel per cycle; intake
//   is set by the single line buffer RAM, one read-modify-write per pixel.
// reset
//   after reset a clearing pass zeroes the 1024 line buffer entries, one per
//   cycle; req_ch.ready stays low until that pass ends. registers return to
//   640 x 480 and the raster position to the top-left.
// stalls
//   a stalled rsp_ch holds its result; a four entry queue absorbs in-flight
//   windows, and req_ch.ready also drops once that queue could overflow.
module rotation_invariant_lbp_3x3_top (
   input  logic        clock,
   input  logic        reset,
   rilbp_req_if.sink   req_ch,
   rilbp_rsp_if.source rsp_ch,
   rilbp_csr_if.sink   csr_ch
);

   rilbp_pkg::rilbp_push_type                push;
   rilbp_pkg::rilbp_head_type                head;
   logic                                     pop;
   logic [rilbp_pkg::QUEUE_COUNT_BITS-1:0]   queue_count;

   // intake, line buffers and window compare
   rilbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .queue_count (queue_count),
      .push        (push)
   );

   // decoupling queue
   rilbp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (queue_count)
   );

   // rotation minimum and output register
   rilbp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

>>> rtl/core/rilbp_ram.sv
// ----------------------------------------------------------------------------
// rilbp_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rilbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rilbp_front.sv
// ----------------------------------------------------------------------------
// rilbp_front
// Pixel intake: raster counters, line buffers, 3x3 window and neighbour compare.
// ----------------------------------------------------------------------------
module rilbp_front (
   input  logic                                         clock,
   input  logic                                         reset,
   rilbp_req_if.sink                                    req_ch,
   rilbp_csr_if.sink                                    csr_ch,
   input  logic [rilbp_pkg::QUEUE_COUNT_BITS-1:0]       queue_count,
   output rilbp_pkg::rilbp_push_type                    push
);

   localparam int PB = rilbp_pkg::PIXEL_BITS;
   localparam int CB = rilbp_pkg::COL_BITS;
   localparam int RB = rilbp_pkg::ROW_BITS;
   localparam int WB = rilbp_pkg::WIDTH_REG_BITS;
   localparam int HB = rilbp_pkg::HEIGHT_REG_BITS;
   localparam int QB = rilbp_pkg::QUEUE_COUNT_BITS;

   // configuration registers
   logic [WB-1:0] image_width_ff, image_width_in;
   logic [HB-1:0] image_height_ff, image_height_in;

   // line buffer clearing pass
   logic          clear_busy_ff, clear_busy_in;
   logic [CB-1:0] clear_addr_ff, clear_addr_in;

   // raster counters
   logic [CB-1:0] column_count_ff, column_count_in;
   logic [RB-1:0] row_count_ff, row_count_in;

   // stage after the line buffer read
   logic          s1_valid_ff, s1_valid_in;
   logic [PB-1:0] s1_pixel_ff, s1_pixel_in;
   logic [CB-1:0] s1_col_ff, s1_col_in;
   logic          s1_emit_ff, s1_emit_in;
   logic          s1_row_last_ff, s1_row_last_in;
   logic          s1_frame_last_ff, s1_frame_last_in;

   // 3x3 window, row major, top-left first
   logic [PB-1:0] window_ff [rilbp_pkg::WINDOW_SIZE];
   logic [PB-1:0] window_in [rilbp_pkg::WINDOW_SIZE];

   logic                               accept;
   logic [QB-1:0]                      pending;
   logic [CB-1:0]                      last_col;
   logic [RB-1:0]                      last_row;
   logic [WB-1:0]                      width_minus_one;
   logic [HB-1:0]                      height_minus_one;
   logic                               end_row;
   logic                               end_frame;
   logic                               emit;
   logic                               ram_wr_en;
   logic [CB-1:0]                      ram_wr_addr;
   logic [rilbp_pkg::LINE_RAM_WIDTH-1:0] ram_wr_data;
   logic [rilbp_pkg::LINE_RAM_WIDTH-1:0] ram_rd_data;
   logic [PB-1:0]                      upper_rd;
   logic [PB-1:0]                      middle_rd;
   logic [PB-1:0]                      centre;

   // space in the queue for everything already in flight
   assign pending      = queue_count + QB'(s1_valid_ff);
   assign req_ch.ready = !clear_busy_ff && (pending < QB'(rilbp_pkg::QUEUE_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // register writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            rilbp_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_ch.data[WB-1:0];
            rilbp_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_ch.data[HB-1:0];
            default: ;
         endcase
      end
   end

   // clamped last column and last row
   assign width_minus_one  = image_width_ff - WB'(1);
   assign height_minus_one = image_height_ff - HB'(1);

   always_comb begin
      if (image_width_ff < WB'(3)) begin
         last_col = CB'(2);
      end else if (image_width_ff > WB'(rilbp_pkg::MAX_WIDTH)) begin
         last_col = CB'(rilbp_pkg::MAX_WIDTH - 1);
      end else begin
         last_col = width_minus_one[CB-1:0];
      end
      if (image_height_ff < HB'(3)) begin
         last_row = RB'(2);
      end else begin
         last_row = RB'(height_minus_one);
      end
   end

   assign end_row   = column_count_ff >= last_col;
   assign end_frame = end_row && (row_count_ff >= last_row);
   assign emit      = (row_count_ff >= RB'(2)) && (column_count_ff >= CB'(2));

   // raster position
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (end_row) begin
            column_count_in = '0;
            row_count_in    = end_frame ? '0 : row_count_ff + RB'(1);
         end else begin
            column_count_in = column_count_ff + CB'(1);
         end
      end
   end

   // clearing pass over the line buffers after reset
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + CB'(1);
         if (clear_addr_ff == CB'(rilbp_pkg::MAX_WIDTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   // stage one capture
   always_comb begin
      s1_valid_in      = accept;
      s1_pixel_in      = req_ch.pixel;
      s1_col_in        = column_count_ff;
      s1_emit_in       = emit;
      s1_row_last_in   = end_row;
      s1_frame_last_in = end_frame;
   end

   // line buffers: read at intake, write back in the following cycle
   assign upper_rd    = ram_rd_data[2*PB-1:PB];
   assign middle_rd   = ram_rd_data[PB-1:0];
   assign ram_wr_en   = clear_busy_ff || s1_valid_ff;
   assign ram_wr_addr = clear_busy_ff ? clear_addr_ff : s1_col_ff;
   assign ram_wr_data = clear_busy_ff ? '0 : {middle_rd, s1_pixel_ff};

   rilbp_ram #(
      .WIDTH (rilbp_pkg::LINE_RAM_WIDTH),
      .DEPTH (rilbp_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (column_count_ff),
      .rd_data (ram_rd_data)
   );

   // window shift: new column enters on the right
   always_comb begin
      for (int i = 0; i < rilbp_pkg::WINDOW_SIZE; i++) begin
         window_in[i] = window_ff[i];
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r*3]     = window_ff[r*3 + 1];
            window_in[r*3 + 1] = window_ff[r*3 + 2];
         end
         window_in[2] = upper_rd;
         window_in[5] = middle_rd;
         window_in[8] = s1_pixel_ff;
      end
   end

   // neighbour compare, clockwise from top-left, top-left in the msb
   assign centre                 = window_in[4];
   assign push.valid             = s1_valid_ff && s1_emit_ff;
   assign push.entry.bits        = {window_in[0] >= centre, window_in[1] >= centre,
                                    window_in[2] >= centre, window_in[5] >= centre,
                                    window_in[8] >= centre, window_in[7] >= centre,
                                    window_in[6] >= centre, window_in[3] >= centre};
   assign push.entry.row_last    = s1_row_last_ff;
   assign push.entry.frame_last  = s1_frame_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rilbp_pkg::WIDTH_RESET;
         image_height_ff <= rilbp_pkg::HEIGHT_RESET;
         clear_busy_ff   <= 1'b1;
         clear_addr_ff   <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         for (int i = 0; i < rilbp_pkg::WINDOW_SIZE; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         clear_busy_ff   <= clear_busy_in;
         clear_addr_ff   <= clear_addr_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
         for (int i = 0; i < rilbp_pkg::WINDOW_SIZE; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff      <= s1_pixel_in;
         s1_col_ff        <= s1_col_in;
         s1_emit_ff       <= s1_emit_in;
         s1_row_last_ff   <= s1_row_last_in;
         s1_frame_last_ff <= s1_frame_last_in;
      end
   end

endmodule

>>> rtl/core/rilbp_fifo.sv
// ----------------------------------------------------------------------------
// rilbp_fifo
// Short queue of compare bytes between the front and the back end.
// ----------------------------------------------------------------------------
module rilbp_fifo (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rilbp_pkg::rilbp_push_type              push,
   input  logic                                   pop,
   output rilbp_pkg::rilbp_head_type              head,
   output logic [rilbp_pkg::QUEUE_COUNT_BITS-1:0] count
);

   localparam int PB = rilbp_pkg::QUEUE_PTR_BITS;
   localparam int QB = rilbp_pkg::QUEUE_COUNT_BITS;

   rilbp_pkg::rilbp_entry_type entry_ff [rilbp_pkg::QUEUE_DEPTH];

   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QB-1:0] count_ff, count_in;
   logic          do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + QB'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - QB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.not_empty = count_ff != '0;
   assign head.entry     = entry_ff[rd_ptr_ff];
   assign count          = count_ff;

endmodule

>>> rtl/core/rilbp_back.sv
// ----------------------------------------------------------------------------
// rilbp_back
// Minimum rotation of the compare byte into the result output register.
// ----------------------------------------------------------------------------
module rilbp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rilbp_pkg::rilbp_head_type head,
   output logic                      pop,
   rilbp_rsp_if.source               rsp_ch
);

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rilbp_pkg::CODE_BITS-1:0] code_ff, code_in;
   logic                            row_last_ff, row_last_in;
   logic                            frame_last_ff, frame_last_in;

   // take the queue head when the output register is free or drains
   assign pop = head.not_empty && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      code_in       = rilbp_pkg::min_rotation(head.entry.bits);
      row_last_in   = head.entry.row_last;
      frame_last_in = head.entry.frame_last;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff       <= code_in;
         row_last_ff   <= row_last_in;
         frame_last_ff <= frame_last_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pattern_code = code_ff;
   assign rsp_ch.row_last     = row_last_ff;
   assign rsp_ch.frame_last   = frame_last_ff;

endmodule

>>> rtl/core/rilbp_checker.sv
// ----------------------------------------------------------------------------
// rilbp_checker
// Port level checks of the LBP block, bound to the top level.
// ----------------------------------------------------------------------------
module rilbp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rilbp_pkg::CODE_BITS-1:0] rsp_pattern_code,
   input logic                            rsp_row_last,
   input logic                            rsp_frame_last
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pattern_code)
         && $stable(rsp_row_last) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // a frame end is always a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_frame_last || rsp_row_last)
      else $error("frame_last without row_last");

   // nothing accepted or shown right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("channel active right after reset");

   // a fresh result follows the intake that caused it through stage one, the queue and the output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("result without a matching pixel");

endmodule

bind rotation_invariant_lbp_3x3_top rilbp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pattern_code (rsp_ch.pattern_code),
   .rsp_row_last     (rsp_ch.row_last),
   .rsp_frame_last   (rsp_ch.frame_last)
);
